// ----- rtl/mbps_pkg.sv -----
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int DATA_BITS       = 8;
    localparam int LEN_BITS        = 5;
    localparam int PAT_BYTES       = 16;
    localparam int CARE_BITS       = 16;
    localparam int OUT_OFFSET_BITS = 32;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK      = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 8'd3;

    localparam logic [CARE_BITS-1:0] CARE_RESET   = 16'hFFFF;
    localparam logic [LEN_BITS-1:0]  LENGTH_RESET = 5'd16;

    typedef struct packed {
        logic shift;
        logic clear;
    } mbps_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/mbps_if.sv -----
`default_nettype none

interface mbps_in_if;
    logic                           valid;
    logic                           ready;
    logic [mbps_pkg::DATA_BITS-1:0] data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic [mbps_pkg::OUT_OFFSET_BITS-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

// ----- rtl/mbps_cell.sv -----
`default_nettype none

module mbps_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mbps_pkg::mbps_ctl_t            ctl,
    input  wire logic [mbps_pkg::DATA_BITS-1:0] byte_in,
    input  wire logic [mbps_pkg::DATA_BITS-1:0] pat_byte,
    input  wire logic                           care,
    output logic      [mbps_pkg::DATA_BITS-1:0] byte_out,
    output logic                                ok
);
    import mbps_pkg::*;

    logic [DATA_BITS-1:0] byte_reg;

    // The byte arriving now is what this cell holds after the shift, so the
    // compare looks at the incoming byte.
    assign ok       = !care || (byte_in == pat_byte);
    assign byte_out = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (ctl.clear)
        begin
            byte_reg <= '0;
        end
        else if (ctl.shift)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mbps_cfg.sv -----
`default_nettype none

module mbps_cfg #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [mbps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic      [PATTERN_MAX*mbps_pkg::DATA_BITS-1:0] aligned_pat,
    output logic      [PATTERN_MAX-1:0]               aligned_care,
    output logic      [mbps_pkg::LEN_BITS-1:0]        pat_len,
    output logic                                      len_ok
);
    import mbps_pkg::*;

    logic [CFG_DATA_BITS-1:0] pat_low_reg;
    logic [CFG_DATA_BITS-1:0] pat_high_reg;
    logic [CARE_BITS-1:0]     care_reg;
    logic [LEN_BITS-1:0]      len_reg;
    logic [PAT_BYTES*DATA_BITS-1:0] pat_all;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= CARE_RESET;
            len_reg      <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                REG_CARE_MASK:      care_reg     <= cfg_data[CARE_BITS-1:0];
                REG_PATTERN_LENGTH: len_reg      <= cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign pat_all = {pat_high_reg, pat_low_reg};
    assign pat_len = len_reg;
    assign len_ok  = (len_reg != '0) && (int'(len_reg) <= PATTERN_MAX);

    // Window cell k (0 = newest) lines up with pattern byte len-1-k. Cells at
    // or beyond the length, and pattern bytes with no register, compare nothing.
    always_comb
    begin
        aligned_pat  = '0;
        aligned_care = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            for (int j = 0; j < PAT_BYTES; j++)
            begin
                if (int'(len_reg) == k + 1 + j)
                begin
                    aligned_pat[k*DATA_BITS +: DATA_BITS] = pat_all[j*DATA_BITS +: DATA_BITS];
                    aligned_care[k] = care_reg[j];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/masked_byte_pattern_search.sv -----
// Channel   Dir   Payload                      Handshake
// in_ch     in    data_byte[7:0], last_byte     valid/ready
// out_ch    out   found, match_offset[31:0]     valid/ready
// cfg       in    cfg_index, cfg_data[63:0]     cfg_we, no back-pressure
//
// One byte is taken per cycle while in_ch.ready is high; a result appears on out_ch in
// the cycle after the byte that decides it is taken, from a single output register.
// All window cells compare in parallel, each against the byte shifting into it, in the cycle it is taken.
// in_ch.ready is low only while a result waits in the output register and
// out_ch.ready is low.
// Reset loads the configuration reset values and clears the window and counters.
`default_nettype none

module masked_byte_pattern_search #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mbps_in_if.sink                                  in_ch,
    mbps_out_if.source                               out_ch
);
    import mbps_pkg::*;

    logic [PATTERN_MAX*DATA_BITS-1:0] aligned_pat;
    logic [PATTERN_MAX-1:0]           aligned_care;
    logic [LEN_BITS-1:0]              pat_len;
    logic                             len_ok;

    logic [DATA_BITS-1:0] chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] cell_ok;
    mbps_ctl_t            ctl;

    logic [OFFSET_BITS-1:0]     count_reg, count_next;
    logic                       found_reg, found_next;
    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [OUT_OFFSET_BITS-1:0] out_offset_reg;

    logic                       accept;
    logic                       saturated;
    logic [OFFSET_BITS-1:0]     count_step;
    logic [OFFSET_BITS-1:0]     len_ext;
    logic [OFFSET_BITS-1:0]     off_full;
    logic [OUT_OFFSET_BITS-1:0] off_out;
    logic                       hit;
    logic                       emit;

    mbps_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .aligned_pat  (aligned_pat),
        .aligned_care (aligned_care),
        .pat_len      (pat_len),
        .len_ok       (len_ok)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign ctl.shift = accept;
    assign ctl.clear = accept && in_ch.last_byte;
    assign chain[0]  = in_ch.data_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        mbps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .byte_in  (chain[k]),
            .pat_byte (aligned_pat[k*DATA_BITS +: DATA_BITS]),
            .care     (aligned_care[k]),
            .byte_out (chain[k+1]),
            .ok       (cell_ok[k])
        );
    end

    assign saturated  = (count_reg == {OFFSET_BITS{1'b1}});
    assign count_step = saturated ? count_reg : count_reg + OFFSET_BITS'(1);
    assign len_ext    = {{(OFFSET_BITS-LEN_BITS){1'b0}}, pat_len};

    assign hit  = !found_reg && len_ok && (count_step >= len_ext) && (&cell_ok);
    assign emit = hit || (!found_reg && in_ch.last_byte);

    assign off_full = saturated ? {OFFSET_BITS{1'b1}} : count_step - len_ext;

    if (OFFSET_BITS > OUT_OFFSET_BITS)
    begin : g_off_sat
        assign off_out = (|off_full[OFFSET_BITS-1:OUT_OFFSET_BITS])
                       ? {OUT_OFFSET_BITS{1'b1}} : off_full[OUT_OFFSET_BITS-1:0];
    end
    else
    begin : g_off_ext
        assign off_out = {{(OUT_OFFSET_BITS-OFFSET_BITS){1'b0}}, off_full};
    end

    always_comb
    begin
        count_next = count_reg;
        found_next = found_reg;
        if (accept)
        begin
            if (in_ch.last_byte)
            begin
                count_next = '0;
                found_next = 1'b0;
            end
            else
            begin
                count_next = count_step;
                found_next = found_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_found_reg  <= hit;
            out_offset_reg <= hit ? off_out : '0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = out_found_reg;
    assign out_ch.match_offset = out_offset_reg;

`ifndef NO_ASSERTIONS
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_offset_reg == '0)
        else $error("result without a match carries a nonzero offset");

    a_region_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.last_byte |=> count_reg == '0 && !found_reg)
        else $error("region state not cleared after the last byte");

    a_found_once: assert property (@(posedge clk) disable iff (!rst_n)
        accept && found_reg |-> !emit)
        else $error("second result given for one region");

    a_found_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> $past(accept && hit) && out_valid_reg && out_found_reg)
        else $error("match flag set without a reported match");
`endif

endmodule

`default_nettype wire
